@@ src/hid_rid_pkg.sv @@
// Shared types and constants for the HID report descriptor Report ID scan.
package hid_rid_pkg;

  // Parse phase of the descriptor item walker.
  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_LSIZE  = 2'd1,
    PH_LTAG   = 2'd2,
    PH_DATA   = 2'd3
  } phase_t;

  // Item prefix byte that opens a long item.
  localparam logic [7:0] LONG_PREFIX   = 8'hFE;
  // Short item length code that stands for four data bytes.
  localparam logic [1:0] LEN_CODE_FOUR = 2'd3;
  // Item type of a global item.
  localparam logic [1:0] TYPE_GLOBAL   = 2'd1;
  // Global item tag of Report ID.
  localparam logic [3:0] TAG_REPORT_ID = 4'd8;

endpackage

@@ src/hid_descriptor_report_id_scan_top.sv @@
// Report ID scan over a HID report descriptor presented one byte per transaction.
// A last byte passes the input register and then the result register before its result shows.
// Throughput: one descriptor byte per cycle; only a last byte waits, and only
// while the result register is full and not taken.
// Reset: synchronous, active low; clears the parse state and both valid flags,
// so the first byte after reset starts a new descriptor.
module hid_descriptor_report_id_scan_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_desc_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_has_report_id,
  output logic       out_truncated
);
  import hid_rid_pkg::*;

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Parse state.
  phase_t     phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  logic       pending_r, pending_nxt;
  logic       found_r, found_nxt;

  // Result register.
  logic       out_valid_r;
  logic       use_rid_r;
  logic       trunc_r;

  logic       advance;
  logic [1:0] len_code;
  logic [2:0] data_len;
  logic       is_rid;
  logic [7:0] bytes_dec;

  // The held byte moves on unless it is a last byte and the result slot is blocked.
  assign advance  = !(in_valid_r && in_last_r && out_valid_r && !out_ready);
  assign in_ready = !in_valid_r || advance;

  // Fields of a short item prefix.
  assign len_code  = in_byte_r[1:0];
  assign data_len  = (len_code == LEN_CODE_FOUR) ? 3'd4 : {1'b0, len_code};
  assign is_rid    = (in_byte_r[3:2] == TYPE_GLOBAL) && (in_byte_r[7:4] == TAG_REPORT_ID);
  assign bytes_dec = (bytes_left_r != 8'd0) ? bytes_left_r - 8'd1 : 8'd0;

  // Next parse state for the held byte; nothing changes once an item was found.
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    pending_nxt    = pending_r;
    found_nxt      = found_r;
    if (!found_r) begin
      case (phase_r)
        PH_PREFIX: begin
          if (in_byte_r == LONG_PREFIX) begin
            phase_nxt = PH_LSIZE;
          end else if (data_len == 3'd0) begin
            found_nxt = is_rid;
          end else begin
            bytes_left_nxt = {5'd0, data_len};
            pending_nxt    = is_rid;
            phase_nxt      = PH_DATA;
          end
        end
        PH_LSIZE: begin
          bytes_left_nxt = in_byte_r;
          phase_nxt      = PH_LTAG;
        end
        PH_LTAG: begin
          pending_nxt = 1'b0;
          phase_nxt   = (bytes_left_r == 8'd0) ? PH_PREFIX : PH_DATA;
        end
        PH_DATA: begin
          bytes_left_nxt = bytes_dec;
          if (bytes_dec == 8'd0) begin
            found_nxt   = pending_r;
            pending_nxt = 1'b0;
            phase_nxt   = PH_PREFIX;
          end
        end
        default: begin
          phase_nxt = PH_PREFIX;
        end
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_desc_byte;
      in_last_r <= in_last;
    end
  end

  // Parse state update; a last byte returns the state to its start values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_PREFIX;
      bytes_left_r <= 8'd0;
      pending_r    <= 1'b0;
      found_r      <= 1'b0;
    end else if (in_valid_r && advance) begin
      if (in_last_r) begin
        phase_r      <= PH_PREFIX;
        bytes_left_r <= 8'd0;
        pending_r    <= 1'b0;
        found_r      <= 1'b0;
      end else begin
        phase_r      <= phase_nxt;
        bytes_left_r <= bytes_left_nxt;
        pending_r    <= pending_nxt;
        found_r      <= found_nxt;
      end
    end
  end

  // Result register, loaded by a last byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_valid_r && in_last_r && advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && in_last_r && advance) begin
      use_rid_r <= found_nxt;
      trunc_r   <= !found_nxt && (phase_nxt != PH_PREFIX);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_has_report_id = use_rid_r;
  assign out_truncated     = trunc_r;

endmodule

@@ src/hid_rid_checker.sv @@
// Port-level checker for the Report ID scan, bound to the top level.
module hid_rid_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_desc_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_has_report_id,
  input logic       out_truncated
);

  // A found Report ID and a truncated item never appear together.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_has_report_id && out_truncated))
    else $error("result reports both a found Report ID and truncation");

  // A held result keeps its fields until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_has_report_id)
                                && $stable(out_truncated))
    else $error("stalled result changed or vanished");

  // Reset empties the result register.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A fresh result follows a last byte accepted through the input and result registers.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result appeared without a last byte");

  // With the result register empty, bytes are never refused.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

endmodule

bind hid_descriptor_report_id_scan_top hid_rid_checker u_hid_rid_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .in_desc_byte      (in_desc_byte),
  .in_last           (in_last),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_has_report_id (out_has_report_id),
  .out_truncated     (out_truncated)
);
